// ===== design/swam_pkg.sv =====
// Shared constants, types and state codes for the sliding window statistics block.
package swam_pkg;

  localparam int DATA_W   = 12;
  localparam int WINDOW   = 10;
  localparam int NZ_W     = 4;
  localparam int CNT_RAW  = $clog2(WINDOW + 1);
  localparam int CNT_W    = (CNT_RAW < NZ_W) ? NZ_W : CNT_RAW;
  // |sum| <= WINDOW * 2^(DATA_W-1); one extra bit for the sign
  localparam int SUM_W    = $clog2(WINDOW * (2 ** (DATA_W - 1))) + 1;
  // |mean| <= 2^(DATA_W-1), so the quotient needs DATA_W magnitude bits
  localparam int QW       = DATA_W;
  localparam int STEP_W   = $clog2(QW);
  localparam int WALK_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  typedef logic signed [DATA_W-1:0] data_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_PREP,
    S_DIV,
    S_DONE
  } state_t;

  typedef struct packed {
    logic             start;
    logic             neg;
    logic [SUM_W-1:0] mag;
    logic [CNT_W-1:0] den;
  } div_req_t;

endpackage

// ===== design/sliding_window_avg_min_max_core.sv =====
// Top level: window cell chain, statistics walk, serial divide and output register.
//
//  channel | handshake           | payload
//  --------+---------------------+-------------------------------------------
//  in      | in_valid / in_ready | sample
//  out     | out_valid/out_ready | average, minimum, maximum, nonzero_count
//
// An item passes through these steps: shift the sample into the cell chain,
// rotate the chain once past the accumulator, start the divider, run the serial
// divide and its done flag, then load the result.
// An all-empty window skips the divide.
// Reset clears every cell to zero, so the window starts as empty slots.
// A result waits in the output register; the next item is taken meanwhile,
// and the block only holds in its final state while an older result is unread.
module sliding_window_avg_min_max_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  swam_pkg::data_t sample,
  output logic            out_valid,
  input  logic            out_ready,
  output swam_pkg::data_t average,
  output swam_pkg::data_t minimum,
  output swam_pkg::data_t maximum,
  output logic [swam_pkg::NZ_W-1:0] nonzero_count
);
  import swam_pkg::*;

  localparam logic [WALK_W-1:0] WALK_LAST = WALK_W'(WINDOW - 1);

  state_t state, state_next;

  // cell chain: cell 0 holds the oldest sample, cell WINDOW-1 the newest
  data_t cell_q   [WINDOW];
  data_t cell_din [WINDOW];
  logic  shift_en;
  logic  in_accept;

  logic [WALK_W-1:0]       walk_cnt;
  logic signed [SUM_W-1:0] sum;
  logic [CNT_W-1:0]        cnt;
  data_t                   lo;
  data_t                   hi;
  data_t                   head;

  div_req_t div_req;
  logic     div_done;
  data_t    div_quot;
  logic     load_out;

  assign in_ready  = (state == S_IDLE);
  assign in_accept = in_valid && in_ready;
  assign head      = cell_q[0];

  // Shifting in the new sample drops the front cell. Before the window fills
  // the front is an empty zero slot, so the kept values match filling in order.
  genvar gi;
  generate
    for (gi = 0; gi < WINDOW; gi++) begin : g_cell
      if (gi == WINDOW - 1) begin : g_tail
        assign cell_din[gi] = (state == S_IDLE) ? sample : cell_q[0];
      end else begin : g_mid
        assign cell_din[gi] = cell_q[gi+1];
      end
      swam_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .shift_en (shift_en),
        .din      (cell_din[gi]),
        .q        (cell_q[gi])
      );
    end
  endgenerate

  swam_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .done (div_done),
    .quot (div_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    shift_en      = 1'b0;
    load_out      = 1'b0;
    div_req.start = 1'b0;
    div_req.neg   = sum[SUM_W-1];
    div_req.mag   = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
    div_req.den   = cnt;
    case (state)
      S_IDLE: begin
        if (in_accept) begin
          shift_en   = 1'b1;
          state_next = S_WALK;
        end
      end
      S_WALK: begin
        // full rotation: the chain ends in its original order
        shift_en = 1'b1;
        if (walk_cnt == WALK_LAST) begin
          state_next = S_PREP;
        end
      end
      S_PREP: begin
        if (cnt == '0) begin
          state_next = S_DONE;
        end else begin
          div_req.start = 1'b1;
          state_next    = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // walk counter and statistics accumulators
  always_ff @(posedge clk) begin
    if (rst) begin
      walk_cnt <= '0;
    end else if (state == S_WALK) begin
      walk_cnt <= (walk_cnt == WALK_LAST) ? '0 : walk_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE) begin
      sum <= '0;
      cnt <= '0;
    end else if (state == S_WALK) begin
      if (head != '0) begin
        sum <= sum + SUM_W'(head);
        cnt <= cnt + 1'b1;
      end
      if (walk_cnt == '0) begin
        lo <= head;
        hi <= head;
      end else begin
        if (head < lo) lo <= head;
        if (head > hi) hi <= head;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      average       <= (cnt == '0) ? data_t'(0) : div_quot;
      minimum       <= lo;
      maximum       <= hi;
      nonzero_count <= cnt[NZ_W-1:0];
    end
  end

  a_accept_walk: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> (state == S_WALK) && !in_ready)
    else $error("accepted item did not start the window walk");

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_PREP) |-> (cnt <= CNT_W'(WINDOW)))
    else $error("nonzero count exceeds window size");

  a_lo_hi: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) && (walk_cnt != '0) |-> (lo <= hi))
    else $error("running minimum above running maximum");

  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV))
    else $error("divider finished outside the divide phase");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    load_out |-> (!out_valid || out_ready))
    else $error("result loaded over an unread result");

endmodule

// ===== design/swam_cell.sv =====
// One window slot: a register that takes its neighbor's value when the chain moves.
module swam_cell (
  input  logic          clk,
  input  logic          rst,
  input  logic          shift_en,
  input  swam_pkg::data_t din,
  output swam_pkg::data_t q
);
  import swam_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else if (shift_en) begin
      q <= din;
    end
  end

endmodule

// ===== design/swam_div.sv =====
// Serial restoring divider: signed sum by nonzero count, one quotient bit per cycle.
module swam_div (
  input  logic               clk,
  input  logic               rst,
  input  swam_pkg::div_req_t req,
  output logic               done,
  output swam_pkg::data_t    quot
);
  import swam_pkg::*;

  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(QW - 1);

  logic              busy;
  logic [STEP_W-1:0] step;
  logic [CNT_W-1:0]  rem;
  logic [CNT_W-1:0]  den;
  logic [QW-1:0]     q;
  logic              neg;
  logic [CNT_W:0]    trial;
  logic [CNT_W:0]    diff;

  assign trial = {rem, q[QW-1]};
  assign diff  = trial - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == STEP_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      // high part is below the divisor since |mean| < 2^QW
      rem <= CNT_W'(req.mag >> QW);
      q   <= req.mag[QW-1:0];
      den <= req.den;
      neg <= req.neg;
    end else if (busy) begin
      if (trial >= {1'b0, den}) begin
        rem <= diff[CNT_W-1:0];
        q   <= {q[QW-2:0], 1'b1};
      end else begin
        rem <= trial[CNT_W-1:0];
        q   <= {q[QW-2:0], 1'b0};
      end
    end
  end

  assign quot = neg ? data_t'(~q + 1'b1) : data_t'(q);

endmodule
